>>> design/stm_pkg.sv
// Package for the set membership table: sizes, operation and status codes,
// and the command/status structs shared by the controller and the datapath.
// No dependencies.
package stm_pkg;

	localparam int CAPACITY  = 16;
	localparam int ELEM_BITS = 32;
	localparam int CNT_W     = 5;
	localparam int OUT_W     = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_ABSENT  = 2'd1,
		ST_PRESENT = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic match;
		logic apply;
	} stm_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_busy;
	} stm_sts_t;

endpackage

>>> design/stm_ctrl.sv
// Controller of the set membership table: sequences accept, match and apply.
// Depends on stm_pkg.
module stm_ctrl import stm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  stm_sts_t sts,
	output stm_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MATCH,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   apply_go;

	// Take a new transfer when idle or when the current item finishes
	always_comb begin
		apply_go  = (state_q == S_APPLY) && !sts.out_busy;
		s_tready  = (state_q == S_IDLE) || apply_go;
		cmd.load  = s_tvalid && s_tready;
		cmd.match = (state_q == S_MATCH);
		cmd.apply = apply_go;
	end

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_MATCH;
				end
				S_MATCH: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (!sts.out_busy) state_q <= s_tvalid ? S_MATCH : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_load_to_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_MATCH)
		else $error("accepted transfer did not enter match");

	a_match_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MATCH |=> state_q == S_APPLY)
		else $error("match not followed by apply");

	a_hold_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPLY && sts.out_busy) |=> state_q == S_APPLY)
		else $error("apply left while output was stalled");

endmodule

>>> design/stm_datapath.sv
// Datapath of the set membership table: slot store with valid marks,
// parallel compare, lowest free slot pick, count and result register.
// Depends on stm_pkg.
module stm_datapath import stm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stm_cmd_t             cmd,
	output stm_sts_t             sts,
	input  logic [1:0]           in_func,
	input  logic [ELEM_BITS-1:0] in_item,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata
);

	// Input stage
	op_t                  func_s1;
	logic [ELEM_BITS-1:0] item_s1;

	// Match stage
	op_t                  func_s2;
	logic [ELEM_BITS-1:0] item_s2;
	logic [CAPACITY-1:0]  hit_vec_s2;
	logic                 hit_any_s2;
	logic [CAPACITY-1:0]  free_sel_s2;
	logic                 full_s2;

	// Slot store and count
	logic [ELEM_BITS-1:0] values_q [CAPACITY];
	logic [CAPACITY-1:0]  valid_q;
	logic [CNT_W-1:0]     count_q;

	// Result register
	logic                 out_valid_q;
	status_t              status_q;
	logic [CNT_W-1:0]     out_count_q;
	logic                 empty_q;

	logic [CAPACITY-1:0]  hit_vec;
	logic [CAPACITY-1:0]  free_vec;
	logic [CAPACITY-1:0]  valid_d;
	logic [CNT_W-1:0]     count_d;
	status_t              status_d;
	logic                 write_en;

	// Hold the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_s1 <= op_t'(in_func);
			item_s1 <= in_item;
		end
	end

	// Compare every slot and pick the lowest free one
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			hit_vec[i] = valid_q[i] && (values_q[i] == item_s1);
		end
		free_vec = ~valid_q & (~(~valid_q) + {{(CAPACITY-1){1'b0}}, 1'b1});
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			func_s2     <= func_s1;
			item_s2     <= item_s1;
			hit_vec_s2  <= hit_vec;
			hit_any_s2  <= |hit_vec;
			free_sel_s2 <= free_vec;
			full_s2     <= &valid_q;
		end
	end

	// Work out the update for the operation
	always_comb begin
		valid_d  = valid_q;
		count_d  = count_q;
		status_d = ST_DONE;
		write_en = 1'b0;
		unique case (func_s2)
			OP_INSERT: begin
				if (hit_any_s2) begin
					status_d = ST_PRESENT;
				end else if (full_s2) begin
					status_d = ST_FULL;
				end else begin
					valid_d  = valid_q | free_sel_s2;
					count_d  = count_q + CNT_W'(1);
					write_en = 1'b1;
				end
			end
			OP_DELETE: begin
				if (hit_any_s2) begin
					valid_d = valid_q & ~hit_vec_s2;
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_ABSENT;
				end
			end
			OP_LOOKUP: begin
				status_d = hit_any_s2 ? ST_DONE : ST_ABSENT;
			end
			OP_CLEAR: begin
				valid_d = '0;
				count_d = '0;
			end
		endcase
	end

	// Write the element into the chosen slot
	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (cmd.apply && write_en && free_sel_s2[i]) values_q[i] <= item_s2;
		end
	end

	// Update valid marks and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (cmd.apply) begin
			valid_q <= valid_d;
			count_q <= count_d;
		end
	end

	// Result register: load on apply, drop when the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			status_q    <= status_d;
			out_count_q <= count_d;
			empty_q     <= (count_d == '0);
		end
	end

	assign sts.out_busy = out_valid_q && !m_tready;
	assign m_tvalid     = out_valid_q;
	assign m_tdata      = {empty_q, out_count_q, status_q};

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(valid_q)))
		else $error("count differs from number of valid slots");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match |-> $onehot0(hit_vec))
		else $error("element held in more than one slot");

	a_apply_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> out_valid_q)
		else $error("apply produced no result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> !sts.out_busy)
		else $error("result overwritten while stalled");

endmodule

>>> design/set_membership_table.sv
// Top level of the set membership table: a bounded set of distinct elements
// in fixed slots. Instantiates stm_ctrl and stm_datapath; uses stm_pkg.
//
//  channel   signals                 payload
//  s_*       tvalid tready tdata     tuser[1:0] func, tdata[31:0] item
//            tuser
//  m_*       tvalid tready tdata     [1:0] status, [6:2] element_count,
//                                    [7] is_empty
//
// Once accepted, each item goes through a registered match step, the
// parallel compare of all slots and free slot pick, then the update.
// A new item is taken in the update cycle, before the last one is through;
// a result reaches m_tvalid through the input, match and result registers.
// Reset clears all valid marks and the count at once; no clearing pass.
// A stalled result holds the update cycle until the transfer completes.
module set_membership_table import stm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [ELEM_BITS-1:0] s_tdata,  // [31:0] item
	input  logic [1:0]           s_tuser,  // [1:0] func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata   // [1:0] status, [6:2] element_count, [7] is_empty
);

	stm_cmd_t cmd;
	stm_sts_t sts;

	stm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	stm_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_func  (s_tuser),
		.in_item  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
